[design/swfp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfp_pkg: shared types and constants for the sliding window frame parser
// Header codes, type and status codes, the result record and its builder.
// ----------------------------------------------------------------------------
package swfp_pkg;

  localparam int unsigned MAX_PAYLOAD = 4096;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TYPE_W = 2;
  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned LEN_W  = 13;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned TDATA_W = 64;

  // header byte codes
  localparam logic [BYTE_W-1:0] HDR_DATA = 8'h01;
  localparam logic [BYTE_W-1:0] HDR_ACK  = 8'h06;
  localparam logic [BYTE_W-1:0] HDR_NAK  = 8'h07;

  // reported frame type
  localparam logic [TYPE_W-1:0] TYPE_DATA = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_ACK  = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_NAK  = 2'd2;
  localparam logic [TYPE_W-1:0] TYPE_UNK  = 2'd3;

  // reported frame status
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_CHK   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_UNK_HDR   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_LEN_RANGE = 3'd3;
  localparam logic [STAT_W-1:0] STAT_CUT_SHORT = 3'd4;

  // result kind
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic              out_kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [TYPE_W-1:0] frame_type;
    logic [SEQ_W-1:0]  seq_number;
    logic [LEN_W-1:0]  payload_len;
    logic [STAT_W-1:0] frame_status;
    logic              frame_end;
  } result_t;

  function automatic result_t make_summary(logic [TYPE_W-1:0] ftype,
                                           logic [SEQ_W-1:0]  seq,
                                           logic [LEN_W-1:0]  len,
                                           logic [STAT_W-1:0] status);
    result_t r;
    r.out_kind     = KIND_SUMMARY;
    r.payload_byte = '0;
    r.frame_type   = ftype;
    r.seq_number   = seq;
    r.payload_len  = len;
    r.frame_status = status;
    r.frame_end    = 1'b1;
    return r;
  endfunction

  function automatic result_t make_payload(logic [BYTE_W-1:0] b);
    result_t r;
    r              = '0;
    r.out_kind     = KIND_PAYLOAD;
    r.payload_byte = b;
    return r;
  endfunction

endpackage

[design/swfp_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfp_core: frame parse state and per-byte result logic
// Holds the parse phase and field accumulators; one byte is consumed per
// accepted transaction and at most one result is produced for it.
// ----------------------------------------------------------------------------
module swfp_core #(
  parameter int unsigned MaxPayload = swfp_pkg::MAX_PAYLOAD
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [swfp_pkg::BYTE_W-1:0]   rx_byte_i,
  input  logic                          frame_start_i,
  output logic                          res_valid_o,
  output swfp_pkg::result_t             res_o
);

  localparam int unsigned RemW = $clog2(MaxPayload + 1);

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_SEQ  = 6'b000010,
    PH_LEN  = 6'b000100,
    PH_PAY  = 6'b001000,
    PH_CHK  = 6'b010000,
    PH_UNK  = 6'b100000
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [1:0]                      idx_q, idx_d;
  logic [swfp_pkg::TYPE_W-1:0]     type_q, type_d;
  logic [swfp_pkg::SEQ_W-1:0]      seq_q, seq_d;
  logic [31:0]                     len_q, len_d;
  logic [RemW-1:0]                 rem_q, rem_d;
  logic [swfp_pkg::BYTE_W-1:0]     sum_q, sum_d;

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    type_d      = type_q;
    seq_d       = seq_q;
    len_d       = len_q;
    rem_d       = rem_q;
    sum_d       = sum_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (frame_start_i) begin
      // close any frame in progress
      unique case (phase_q) inside
        PH_SEQ, PH_LEN, PH_PAY, PH_CHK: begin
          res_valid_o = 1'b1;
          res_o = swfp_pkg::make_summary(type_q, seq_q, len_q[swfp_pkg::LEN_W-1:0],
                                         swfp_pkg::STAT_CUT_SHORT);
        end
        PH_UNK: begin
          res_valid_o = 1'b1;
          res_o = swfp_pkg::make_summary(swfp_pkg::TYPE_UNK, '0, '0,
                                         swfp_pkg::STAT_UNK_HDR);
        end
        default: ;
      endcase
      sum_d   = rx_byte_i;
      seq_d   = '0;
      len_d   = '0;
      idx_d   = '0;
      rem_d   = '0;
      phase_d = PH_SEQ;
      case (rx_byte_i)
        swfp_pkg::HDR_DATA: type_d = swfp_pkg::TYPE_DATA;
        swfp_pkg::HDR_ACK:  type_d = swfp_pkg::TYPE_ACK;
        swfp_pkg::HDR_NAK:  type_d = swfp_pkg::TYPE_NAK;
        default: begin
          type_d = swfp_pkg::TYPE_UNK;
          if (!res_valid_o) begin
            res_valid_o = 1'b1;
            res_o = swfp_pkg::make_summary(swfp_pkg::TYPE_UNK, '0, '0,
                                           swfp_pkg::STAT_UNK_HDR);
            phase_d = PH_IDLE;
          end else begin
            // unknown-header summary waits one transaction
            phase_d = PH_UNK;
          end
        end
      endcase
    end else begin
      unique case (phase_q)
        PH_UNK: begin
          res_valid_o = 1'b1;
          res_o = swfp_pkg::make_summary(swfp_pkg::TYPE_UNK, '0, '0,
                                         swfp_pkg::STAT_UNK_HDR);
          phase_d = PH_IDLE;
        end
        PH_SEQ: begin
          case (idx_q)
            2'd0:    seq_d[7:0]   = rx_byte_i;
            2'd1:    seq_d[15:8]  = rx_byte_i;
            2'd2:    seq_d[23:16] = rx_byte_i;
            default: seq_d[31:24] = rx_byte_i;
          endcase
          sum_d = sum_q + rx_byte_i;
          if (idx_q == 2'd3) begin
            idx_d   = '0;
            phase_d = (type_q == swfp_pkg::TYPE_DATA) ? PH_LEN : PH_CHK;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
        PH_LEN: begin
          case (idx_q)
            2'd0:    len_d[7:0]   = rx_byte_i;
            2'd1:    len_d[15:8]  = rx_byte_i;
            2'd2:    len_d[23:16] = rx_byte_i;
            default: len_d[31:24] = rx_byte_i;
          endcase
          sum_d = sum_q + rx_byte_i;
          if (idx_q == 2'd3) begin
            idx_d = '0;
            if (len_d > 32'(MaxPayload)) begin
              res_valid_o = 1'b1;
              res_o = swfp_pkg::make_summary(swfp_pkg::TYPE_DATA, seq_q, '0,
                                             swfp_pkg::STAT_LEN_RANGE);
              phase_d = PH_IDLE;
            end else begin
              rem_d   = len_d[RemW-1:0];
              phase_d = (len_d != '0) ? PH_PAY : PH_CHK;
            end
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
        PH_PAY: begin
          sum_d       = sum_q + rx_byte_i;
          res_valid_o = 1'b1;
          res_o       = swfp_pkg::make_payload(rx_byte_i);
          rem_d       = rem_q - RemW'(1);
          if (rem_q == RemW'(1)) phase_d = PH_CHK;
        end
        PH_CHK: begin
          res_valid_o = 1'b1;
          res_o = swfp_pkg::make_summary(
                    type_q, seq_q,
                    (type_q == swfp_pkg::TYPE_DATA) ? len_q[swfp_pkg::LEN_W-1:0] : '0,
                    (rx_byte_i == ~sum_q) ? swfp_pkg::STAT_OK : swfp_pkg::STAT_BAD_CHK);
          phase_d = PH_IDLE;
        end
        default: ;  // idle: stray bytes between frames are dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= '0;
      type_q  <= '0;
      seq_q   <= '0;
      len_q   <= '0;
      rem_q   <= '0;
      sum_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      type_q  <= type_d;
      seq_q   <= seq_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      sum_q   <= sum_d;
    end
  end

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("parse phase not one-hot");

  a_pay_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAY |-> rem_q != '0)
    else $error("payload phase with nothing remaining");

  a_payload_only_in_pay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_valid_o && res_o.out_kind == swfp_pkg::KIND_PAYLOAD
      |-> phase_q == PH_PAY && !frame_start_i)
    else $error("payload result outside payload phase");

endmodule

[design/swfp_out_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfp_out_reg: result register toward the output stream
// Holds one result until taken; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module swfp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  swfp_pkg::result_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  output swfp_pkg::result_t data_o,
  input  logic              take_i
);

  logic              valid_q, valid_d;
  swfp_pkg::result_t data_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = load_i || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[design/sliding_window_frame_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_frame_parser: byte-stream frame parser
// Parses data / ack / nak frames, forwards payload bytes and reports one
// summary per frame with type, sequence number, length and status.
// ----------------------------------------------------------------------------
//
//  Channel   | Direction | tdata (low bit first)                      | tuser       | tlast
//  ----------+-----------+--------------------------------------------+-------------+----------
//  s_axis    | in        | rx_byte[7:0]                               | frame_start | -
//  m_axis    | out       | payload_byte, frame_type, seq_number,      | out_kind    | frame_end
//            |           | payload_len, frame_status, zero pad        |             |
//
//  One byte per cycle while the output register is empty or being drained:
//  each input transaction is parsed in the cycle it is accepted and its
//  result (if any) lands in the output register.
//  s_axis_tready_o follows the output register: high when it is empty or is
//  being drained, so the stream runs at full rate while m_axis_tready_i is high.
//  A stall on m_axis holds the result and stops new bytes; nothing is dropped.
//  Asynchronous active-low reset returns the parser to idle, output empty.
// ----------------------------------------------------------------------------
module sliding_window_frame_parser #(
  parameter int unsigned MaxPayload = swfp_pkg::MAX_PAYLOAD
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [swfp_pkg::BYTE_W-1:0]     s_axis_tdata_i,   // [7:0] rx_byte
  input  logic                            s_axis_tuser_i,   // frame_start
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [7:0] payload_byte, [9:8] frame_type, [41:10] seq_number,
  // [54:42] payload_len, [57:55] frame_status, [63:58] zero
  output logic [swfp_pkg::TDATA_W-1:0]    m_axis_tdata_o,
  output logic                            m_axis_tuser_o,   // out_kind
  output logic                            m_axis_tlast_o    // frame_end
);

  logic              accept;
  logic              res_valid;
  swfp_pkg::result_t res;
  swfp_pkg::result_t out_res;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  swfp_core #(
    .MaxPayload(MaxPayload)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (s_axis_tdata_i),
    .frame_start_i (s_axis_tuser_i),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  swfp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept && res_valid),
    .data_i  (res),
    .ready_o (s_axis_tready_o),
    .valid_o (m_axis_tvalid_o),
    .data_o  (out_res),
    .take_i  (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {6'b0, out_res.frame_status, out_res.payload_len,
                           out_res.seq_number, out_res.frame_type,
                           out_res.payload_byte};
  assign m_axis_tuser_o = out_res.out_kind;
  assign m_axis_tlast_o = out_res.frame_end;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output register");

  a_payload_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == swfp_pkg::KIND_PAYLOAD
      |-> !m_axis_tlast_o && m_axis_tdata_o[63:8] == '0)
    else $error("payload transaction carries summary fields");

  a_summary_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == swfp_pkg::KIND_SUMMARY
      |-> m_axis_tlast_o && m_axis_tdata_o[7:0] == '0)
    else $error("summary transaction malformed");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sliding window frame parser
// Feeds directed and random byte streams (good, bad-checksum, oversize,
// cut-short and unknown-header frames, plus stray bytes) under random
// back-pressure, predicts every result transaction and checks it field by field.
// ----------------------------------------------------------------------------
module testbench;
  import swfp_pkg::*;

  typedef enum logic [2:0] {
    PARSE_IDLE,
    PARSE_SEQ,
    PARSE_LEN,
    PARSE_PAYLOAD,
    PARSE_CHECK,
    PARSE_UNK_HELD
  } parse_phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              start;
  } rx_byte_t;

  localparam int unsigned RANDOM_ITEMS = 1450;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [BYTE_W-1:0]   s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]  m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  rx_byte_t            pending_bytes[$];
  result_t             expected_results[$];
  logic [BYTE_W-1:0]   frame_bytes[$];

  int unsigned         send_idle_pct = 21;
  int unsigned         recv_idle_pct = 55;
  int unsigned         stim_count = 0;
  bit                  in_taken = 1'b0;
  bit                  run_failed = 1'b0;

  // parser state mirror
  parse_phase_e        pp_phase = PARSE_IDLE;
  logic [1:0]          pp_idx = '0;
  logic [TYPE_W-1:0]   pp_type = TYPE_DATA;
  logic [31:0]         pp_seq = '0;
  logic [31:0]         pp_len = '0;
  logic [LEN_W-1:0]    pp_remaining = '0;
  logic [7:0]          pp_sum = '0;

  sliding_window_frame_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic result_t summary_of(logic [TYPE_W-1:0] ftype, logic [SEQ_W-1:0] seq,
                                         logic [LEN_W-1:0] len, logic [STAT_W-1:0] status);
    result_t r;
    r = '0;
    r.out_kind     = KIND_SUMMARY;
    r.frame_type   = ftype;
    r.seq_number   = seq;
    r.payload_len  = len;
    r.frame_status = status;
    r.frame_end    = 1'b1;
    return r;
  endfunction

  // Advances the parser mirror by one accepted byte and queues what it yields.
  task automatic predict_parse(input logic [BYTE_W-1:0] b, input logic start);
    result_t r;
    bit      closed;
    closed = 1'b0;
    if (start) begin
      // a header byte closes whatever frame is still open
      if (pp_phase != PARSE_IDLE && pp_phase != PARSE_UNK_HELD) begin
        expected_results.push_back(summary_of(pp_type, pp_seq, pp_len[LEN_W-1:0],
                                              STAT_CUT_SHORT));
        closed = 1'b1;
      end else if (pp_phase == PARSE_UNK_HELD) begin
        expected_results.push_back(summary_of(TYPE_UNK, '0, '0, STAT_UNK_HDR));
        closed = 1'b1;
      end
      pp_sum       = b;
      pp_seq       = '0;
      pp_len       = '0;
      pp_idx       = '0;
      pp_remaining = '0;
      pp_phase     = PARSE_SEQ;
      case (b)
        HDR_DATA: pp_type = TYPE_DATA;
        HDR_ACK:  pp_type = TYPE_ACK;
        HDR_NAK:  pp_type = TYPE_NAK;
        default: begin
          pp_type = TYPE_UNK;
          // only one result per byte: hold the unknown-header report if busy
          if (!closed) begin
            expected_results.push_back(summary_of(TYPE_UNK, '0, '0, STAT_UNK_HDR));
            pp_phase = PARSE_IDLE;
          end else begin
            pp_phase = PARSE_UNK_HELD;
          end
        end
      endcase
    end else begin
      case (pp_phase)
        PARSE_UNK_HELD: begin
          expected_results.push_back(summary_of(TYPE_UNK, '0, '0, STAT_UNK_HDR));
          pp_phase = PARSE_IDLE;
        end
        PARSE_SEQ: begin
          pp_seq[8*pp_idx +: 8] = b;
          pp_sum = pp_sum + b;
          if (pp_idx == 2'd3) begin
            pp_idx   = '0;
            pp_phase = (pp_type == TYPE_DATA) ? PARSE_LEN : PARSE_CHECK;
          end else begin
            pp_idx = pp_idx + 2'd1;
          end
        end
        PARSE_LEN: begin
          pp_len[8*pp_idx +: 8] = b;
          pp_sum = pp_sum + b;
          if (pp_idx != 2'd3) begin
            pp_idx = pp_idx + 2'd1;
          end else begin
            pp_idx = '0;
            if (pp_len > MAX_PAYLOAD) begin
              expected_results.push_back(summary_of(TYPE_DATA, pp_seq, '0, STAT_LEN_RANGE));
              pp_phase = PARSE_IDLE;
            end else begin
              pp_remaining = pp_len[LEN_W-1:0];
              pp_phase     = (pp_remaining != '0) ? PARSE_PAYLOAD : PARSE_CHECK;
            end
          end
        end
        PARSE_PAYLOAD: begin
          pp_sum = pp_sum + b;
          r = '0;
          r.out_kind     = KIND_PAYLOAD;
          r.payload_byte = b;
          expected_results.push_back(r);
          if (pp_remaining != '0) pp_remaining = pp_remaining - 1'b1;
          if (pp_remaining == '0) pp_phase = PARSE_CHECK;
        end
        PARSE_CHECK: begin
          expected_results.push_back(summary_of(pp_type, pp_seq,
              (pp_type == TYPE_DATA) ? pp_len[LEN_W-1:0] : '0,
              (b == ~pp_sum) ? STAT_OK : STAT_BAD_CHK));
          pp_phase = PARSE_IDLE;
        end
        default: ;  // stray byte between frames
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      run_failed = 1'b1;
    end
  endtask

  // Monitor: result side first (it belongs to an earlier byte), then input side.
  always @(posedge clk_i) begin : monitor
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with none expected: tdata %0h", m_axis_tdata);
          run_failed = 1'b1;
        end else begin
          want = expected_results.pop_front();
          check_field("out_kind",     want.out_kind,     m_axis_tuser);
          check_field("payload_byte", want.payload_byte, m_axis_tdata[7:0]);
          check_field("frame_type",   want.frame_type,   m_axis_tdata[9:8]);
          check_field("seq_number",   want.seq_number,   m_axis_tdata[41:10]);
          check_field("payload_len",  want.payload_len,  m_axis_tdata[54:42]);
          check_field("frame_status", want.frame_status, m_axis_tdata[57:55]);
          check_field("frame_end",    want.frame_end,    m_axis_tlast);
          check_field("tdata pad",    '0,                m_axis_tdata[63:58]);
        end
      end
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) predict_parse(s_axis_tdata, s_axis_tuser);
    end
  end

  // Driver: new byte offered only when the slot is free; random gaps and stalls.
  always @(negedge clk_i) begin : driver
    rx_byte_t          nxt;
    logic              nv;
    logic [BYTE_W-1:0] nd;
    logic              nu;
    if (rst_ni) begin
      nv = s_axis_tvalid;
      nd = s_axis_tdata;
      nu = s_axis_tuser;
      if (!s_axis_tvalid || in_taken) begin
        nv = 1'b0;
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_bytes.pop_front();
          nv  = 1'b1;
          nd  = nxt.data;
          nu  = nxt.start;
        end
      end
      s_axis_tvalid <= nv;
      s_axis_tdata  <= nd;
      s_axis_tuser  <= nu;
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_byte(input logic [BYTE_W-1:0] b, input logic start, input bit counted);
    rx_byte_t x;
    x.data  = b;
    x.start = start;
    pending_bytes.push_back(x);
    if (counted) stim_count++;
  endtask

  // Builds header, sequence, optional length and payload, then the checksum.
  task automatic build_frame(input logic [BYTE_W-1:0] hdr, input logic [31:0] seqv,
                             input logic [31:0] lenv, input int unsigned n_pay,
                             input bit good_chk);
    logic [7:0] sum;
    frame_bytes.delete();
    frame_bytes.push_back(hdr);
    for (int i = 0; i < 4; i++) frame_bytes.push_back(seqv[8*i +: 8]);
    if (hdr == HDR_DATA) begin
      for (int i = 0; i < 4; i++) frame_bytes.push_back(lenv[8*i +: 8]);
      for (int i = 0; i < n_pay; i++) frame_bytes.push_back(8'($urandom));
    end
    sum = '0;
    foreach (frame_bytes[i]) sum = sum + frame_bytes[i];
    frame_bytes.push_back(good_chk ? ~sum : 8'($urandom));
  endtask

  task automatic send_frame(input int unsigned keep);
    for (int i = 0; i < keep; i++) add_byte(frame_bytes[i], (i == 0), 1'b1);
  endtask

  task automatic add_random_frames(input int unsigned target);
    int unsigned       pick;
    int unsigned       plen;
    logic [31:0]       lenv;
    logic [BYTE_W-1:0] hdr;
    while (stim_count < target) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        plen = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
        build_frame(HDR_DATA, $urandom, plen, plen, $urandom_range(9) != 0);
        send_frame(frame_bytes.size());
      end else if (pick < 65) begin
        build_frame($urandom_range(1) ? HDR_ACK : HDR_NAK, $urandom, 0, 0,
                    $urandom_range(9) != 0);
        send_frame(frame_bytes.size());
      end else if (pick < 73) begin
        // oversize length: reported at the last length byte, rest ignored
        lenv = $urandom_range(1) ? 32'($urandom_range(MAX_PAYLOAD + 1, 8191))
                                 : ($urandom | 32'h0001_0000);
        build_frame(HDR_DATA, $urandom, lenv, 0, 1'b1);
        send_frame(9);
        repeat ($urandom_range(3)) add_byte(8'($urandom), 1'b0, 1'b0);
      end else if (pick < 85) begin
        // cut short: the next header byte aborts this frame
        if ($urandom_range(1)) begin
          plen = $urandom_range(12);
          build_frame(HDR_DATA, $urandom, plen, plen, 1'b1);
        end else begin
          build_frame($urandom_range(1) ? HDR_ACK : HDR_NAK, $urandom, 0, 0, 1'b1);
        end
        send_frame($urandom_range(1, frame_bytes.size() - 1));
      end else if (pick < 93) begin
        do hdr = 8'($urandom);
        while (hdr == HDR_DATA || hdr == HDR_ACK || hdr == HDR_NAK);
        add_byte(hdr, 1'b1, 1'b1);
        repeat ($urandom_range(2)) add_byte(8'($urandom), 1'b0, 1'b0);
      end else begin
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom), 1'b0, 1'b0);
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || s_axis_tvalid) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned guard;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // stray byte while idle
    add_byte(8'h00, 1'b0, 1'b1);
    // ack cut short by an unknown header; held report comes on the next byte
    add_byte(HDR_ACK, 1'b1, 1'b1);
    add_byte(8'hAA, 1'b0, 1'b1);
    add_byte(8'hFE, 1'b1, 1'b1);
    add_byte(8'h12, 1'b0, 1'b1);
    // nak cut short by unknown header; held report is emitted at the next header
    add_byte(HDR_NAK, 1'b1, 1'b1);
    add_byte(8'h33, 1'b1, 1'b1);
    // data frame with all-ones sequence and length 4097 (just over the max)
    build_frame(HDR_DATA, 32'hFFFF_FFFF, MAX_PAYLOAD + 1, 0, 1'b1);
    send_frame(9);
    // zero-length data frame: checksum follows the length directly
    build_frame(HDR_DATA, 32'h0, 32'h0, 0, 1'b1);
    send_frame(frame_bytes.size());

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle_pct = 21; recv_idle_pct = 55; end
        1: begin send_idle_pct = 55; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      // length of exactly the max is accepted; the frame is cut short by what follows
      if (p == 2) begin
        build_frame(HDR_DATA, $urandom, MAX_PAYLOAD, 24, 1'b1);
        send_frame(33);
      end
      add_random_frames(stim_count + RANDOM_ITEMS / 3);
      wait_drained();
    end

    guard = 0;
    while (expected_results.size() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      run_failed = 1'b1;
    end
    if (!run_failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
